FILE: rtl/core/swms_pkg.sv
// swms_pkg: sizes, span and tag types shared by the sliding window spread unit.
// No dependencies; imported by every module of the block.
package swms_pkg;

    localparam int WINDOW_MAX = 1024;
    localparam int DATA_W     = 32;
    localparam int LEN_W      = 11;
    localparam int IDX_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int TREE_N     = 1 << IDX_W;
    localparam int FILL_W     = $clog2(WINDOW_MAX + 1);

    // running max and min over the newest samples
    typedef struct packed {
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] lo;
    } span_t;

    // sideband that travels with each transaction down the select tree
    typedef struct packed {
        logic             eval;
        logic             last;
        logic [IDX_W-1:0] idx;
    } tag_t;

endpackage

FILE: rtl/core/swms_cell.sv
// swms_cell: one link of the window chain, holding max and min of the newest samples.
// Depends on swms_pkg.
module swms_cell
    import swms_pkg::*;
(
    input  logic              clk,
    input  logic              shift_en,
    input  logic              head,
    input  logic [DATA_W-1:0] sample,
    input  span_t             prev,
    output span_t             span
);

    span_t span_reg;
    span_t span_next;

    // extend the neighbour's span by the new sample; the head cell restarts
    always_comb
    begin
        if (head)
        begin
            span_next.hi = sample;
            span_next.lo = sample;
        end
        else
        begin
            span_next.hi = (sample > prev.hi) ? sample : prev.hi;
            span_next.lo = (sample < prev.lo) ? sample : prev.lo;
        end
    end

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            span_reg <= span_next;
        end
    end

    assign span = span_reg;

endmodule

FILE: rtl/core/swms_sel_tree.sv
// swms_sel_tree: registered binary select tree picking the cell at the window length.
// Depends on swms_pkg.
module swms_sel_tree
    import swms_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    input  tag_t  in_tag,
    input  span_t leaf [TREE_N],
    output logic  out_valid,
    output tag_t  out_tag,
    output span_t root
);

    logic  valid_reg [IDX_W+1];
    tag_t  tag_reg   [IDX_W+1];
    span_t node_reg  [1:TREE_N-1];

    // sideband pipeline, stage 0 lines up with the chain update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= IDX_W; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= IDX_W; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        tag_reg[0] <= in_tag;
        for (int k = 1; k <= IDX_W; k++)
        begin
            tag_reg[k] <= tag_reg[k-1];
        end
    end

    // tree nodes: depth d selects on index bit IDX_W-1-d, one level a cycle
    for (genvar i = 1; i < TREE_N; i++)
    begin : g_node
        localparam int D = $clog2(i + 1) - 1;
        localparam int B = IDX_W - 1 - D;
        span_t a;
        span_t b;
        span_t node_next;
        if (2 * i >= TREE_N)
        begin : g_leaf
            assign a = leaf[2*i - TREE_N];
            assign b = leaf[2*i + 1 - TREE_N];
        end
        else
        begin : g_inner
            assign a = node_reg[2*i];
            assign b = node_reg[2*i + 1];
        end
        assign node_next = tag_reg[B].idx[B] ? b : a;
        always_ff @(posedge clk)
        begin
            node_reg[i] <= node_next;
        end
    end

    assign out_valid = valid_reg[IDX_W];
    assign out_tag   = tag_reg[IDX_W];
    assign root      = node_reg[1];

endmodule

FILE: rtl/core/sliding_window_max_spread_unit.sv
// sliding_window_max_spread_unit: top level, window chain, select tree and spread tracking.
// Depends on swms_pkg, swms_cell and swms_sel_tree.
//
//  channel | signals                                   | direction
//  input   | in_valid, in_stall, sample, last_sample   | samples in
//  output  | out_valid, out_stall, max_spread          | one spread per record
//  config  | cfg_valid, cfg_ready, window_length       | window length write
//
// One sample per cycle is taken while in_stall is low; the chain of cells updates
// in the cycle of acceptance. A result passes the select tree, then the output register.
// After a last sample, input stalls until its result reaches the output register.
// Async reset clears control state and sets window length to 1; cell contents need no reset.
module sliding_window_max_spread_unit
    import swms_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [DATA_W-1:0] sample,
    input  logic              last_sample,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [DATA_W-1:0] max_spread,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [LEN_W-1:0]  window_length
);

    logic [LEN_W-1:0]  wl_reg;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [DATA_W-1:0] best_reg;
    logic [DATA_W-1:0] best_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [DATA_W-1:0] out_data_reg;
    logic [DATA_W-1:0] out_data_next;
    logic              last_pend_reg;
    logic              last_pend_next;

    logic              accept;
    logic [FILL_W-1:0] len_eff;
    logic [FILL_W-1:0] fill_inc;
    tag_t              in_tag;
    span_t             cell_span [TREE_N];
    logic              tree_valid;
    tag_t              tree_tag;
    span_t             tree_root;
    logic [DATA_W-1:0] spread;

    assign cfg_ready = 1'b1;
    assign accept    = in_valid && !in_stall;
    assign in_stall  = last_pend_reg || (out_valid_reg && last_sample);

    // effective window length, clamped to 1..WINDOW_MAX
    always_comb
    begin
        if (wl_reg == '0)
        begin
            len_eff = FILL_W'(1);
        end
        else if (32'(wl_reg) > 32'(WINDOW_MAX))
        begin
            len_eff = FILL_W'(WINDOW_MAX);
        end
        else
        begin
            len_eff = FILL_W'(wl_reg);
        end
    end

    // fill count saturates at the store depth
    assign fill_inc = (32'(fill_reg) >= 32'(WINDOW_MAX)) ? fill_reg : fill_reg + FILL_W'(1);

    always_comb
    begin
        in_tag.eval = (fill_inc >= len_eff);
        in_tag.last = last_sample;
        in_tag.idx  = IDX_W'(len_eff - FILL_W'(1));
    end

    // chain of cells: cell k holds max and min of the newest k+1 samples
    for (genvar k = 0; k < TREE_N; k++)
    begin : g_cell
        if (k < WINDOW_MAX)
        begin : g_live
            if (k == 0)
            begin : g_head
                swms_cell u_cell (
                    .clk      (clk),
                    .shift_en (accept),
                    .head     (1'b1),
                    .sample   (sample),
                    .prev     ('0),
                    .span     (cell_span[k])
                );
            end
            else
            begin : g_link
                swms_cell u_cell (
                    .clk      (clk),
                    .shift_en (accept),
                    .head     (1'b0),
                    .sample   (sample),
                    .prev     (cell_span[k-1]),
                    .span     (cell_span[k])
                );
            end
        end
        else
        begin : g_pad
            assign cell_span[k] = '0;
        end
    end

    swms_sel_tree u_tree (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .in_tag    (in_tag),
        .leaf      (cell_span),
        .out_valid (tree_valid),
        .out_tag   (tree_tag),
        .root      (tree_root)
    );

    assign spread = tree_root.hi - tree_root.lo;

    // record tracking and result capture
    always_comb
    begin
        fill_next      = fill_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_data_next  = out_data_reg;
        last_pend_next = last_pend_reg;
        if (accept)
        begin
            fill_next = last_sample ? '0 : fill_inc;
            if (last_sample)
            begin
                last_pend_next = 1'b1;
            end
        end
        if (tree_valid)
        begin
            if (tree_tag.eval && (spread > best_reg))
            begin
                best_next = spread;
            end
            if (tree_tag.last)
            begin
                out_data_next  = best_next;
                out_valid_next = 1'b1;
                best_next      = '0;
                last_pend_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wl_reg        <= LEN_W'(1);
            fill_reg      <= '0;
            best_reg      <= '0;
            out_valid_reg <= 1'b0;
            last_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                wl_reg <= window_length;
            end
            fill_reg      <= fill_next;
            best_reg      <= best_next;
            out_valid_reg <= out_valid_next;
            last_pend_reg <= last_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid  = out_valid_reg;
    assign max_spread = out_data_reg;

endmodule

FILE: rtl/core/swms_checker.sv
// swms_checker: port-level assertions for the sliding window spread unit, with its bind.
// Depends on swms_pkg; attaches to sliding_window_max_spread_unit.
module swms_checker
    import swms_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_stall,
    input logic              last_sample,
    input logic              out_valid,
    input logic              out_stall,
    input logic [DATA_W-1:0] max_spread
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(max_spread))
        else $error("result changed under stall");

    // an accepted last sample blocks the input until its result is out
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_sample |=> in_stall)
        else $error("input open while a record end is in flight");

    // no two results back to back
    a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> !out_valid)
        else $error("second result right after a delivered one");

    // a waiting result keeps the next record end out
    a_pending_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last_sample |-> in_stall)
        else $error("record end accepted while a result waits");

endmodule

bind sliding_window_max_spread_unit swms_checker u_swms_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .last_sample (last_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .max_spread  (max_spread)
);

FILE: tb/sv/testbench.sv
// testbench: checks sliding_window_max_spread_unit against its own spread predictor.
// Depends on swms_pkg and the RTL of the unit; stands alone otherwise.
module testbench;
    import swms_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int DRAIN_CYCLES = 40;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    logic [DATA_W-1:0] sample;
    logic              last_sample;
    logic              out_valid;
    logic              out_stall;
    logic [DATA_W-1:0] max_spread;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [LEN_W-1:0]  window_length;

    sliding_window_max_spread_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .sample(sample), .last_sample(last_sample),
        .out_valid(out_valid), .out_stall(out_stall), .max_spread(max_spread),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .window_length(window_length)
    );

    // predictor state
    logic [DATA_W-1:0] hist_q [$];
    int unsigned       seen_cnt;
    logic [DATA_W-1:0] best_q;
    logic [LEN_W-1:0]  len_reg;
    logic [DATA_W-1:0] spread_q [$];

    int unsigned cycle_cnt;
    int unsigned err_cnt;
    int unsigned result_cnt;
    int unsigned record_cnt;
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_off;

    // directed rows: sample, last, expected spread where obvious (else -1)
    typedef struct {
        logic [DATA_W-1:0] smp;
        logic              lst;
        longint            want;
    } row_t;
    row_t rows [$];

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    // timeout guard
    initial
    begin
        wait (cycle_cnt >= LIMIT_CYCLES);
        $display("timeout after %0d cycles", cycle_cnt);
        $display("testbench: done, errors");
        $finish;
    end

    // spread for one accepted sample
    function automatic void predict_sample(input logic [DATA_W-1:0] s, input logic l);
        int unsigned       eff;
        logic [DATA_W-1:0] hi;
        logic [DATA_W-1:0] lo;
        begin
            eff = (len_reg == 0) ? 1 : ((len_reg > WINDOW_MAX) ? WINDOW_MAX : len_reg);
            hist_q.push_front(s);
            if (hist_q.size() > WINDOW_MAX)
                void'(hist_q.pop_back());
            if (seen_cnt < WINDOW_MAX)
                seen_cnt++;
            if (seen_cnt >= eff)
            begin
                hi = hist_q[0];
                lo = hist_q[0];
                for (int k = 1; k < eff; k++)
                begin
                    if (hist_q[k] > hi) hi = hist_q[k];
                    if (hist_q[k] < lo) lo = hist_q[k];
                end
                if (hi - lo > best_q)
                    best_q = hi - lo;
            end
            if (l)
            begin
                spread_q.push_back(best_q);
                seen_cnt = 0;
                best_q = '0;
            end
        end
    endfunction

    // input monitor feeds the predictor
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            predict_sample(sample, last_sample);
    end

    // output checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            result_cnt++;
            if (spread_q.size() == 0)
            begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected result %h", max_spread);
            end
            else
            begin
                if (max_spread !== spread_q[0])
                begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("max_spread mismatch: expected %h actual %h",
                                 spread_q[0], max_spread);
                end
                void'(spread_q.pop_front());
            end
        end
    end

    // receiver stall
    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end

    // long hold-off of the receiver, counted here
    task automatic long_hold(input int unsigned n);
        begin
            hold_off = 1'b1;
            repeat (n) @(posedge clk);
            hold_off = 1'b0;
        end
    endtask

    task automatic write_length(input logic [LEN_W-1:0] v);
        begin
            @(negedge clk);
            cfg_valid     <= 1'b1;
            window_length <= v;
            do @(posedge clk); while (!cfg_ready);
            @(negedge clk);
            cfg_valid <= 1'b0;
            len_reg = v;
        end
    endtask

    // wait for every spread, then for the tree to drain
    task automatic wait_drained;
        begin
            while (spread_q.size() != 0) @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
        end
    endtask

    task automatic send_sample(input logic [DATA_W-1:0] s, input logic l);
        begin
            while ($urandom_range(99, 0) < send_idle_pct)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            @(negedge clk);
            in_valid    <= 1'b1;
            sample      <= s;
            last_sample <= l;
            do @(posedge clk); while (in_stall);
            @(negedge clk);
            in_valid <= 1'b0;
            if (l) record_cnt++;
        end
    endtask

    function automatic logic [DATA_W-1:0] rand_sample(input int unsigned mode);
        begin
            case (mode)
                0: rand_sample = '0;
                1: rand_sample = '1;
                2: rand_sample = $urandom_range(15, 0);
                default: rand_sample = $urandom;
            endcase
        end
    endfunction

    // one record of n samples with random content, in a mode picked per record
    task automatic random_record(input int unsigned n);
        int unsigned mode;
        begin
            mode = $urandom_range(4, 0);
            for (int i = 0; i < n; i++)
                send_sample(rand_sample((mode == 4) ? $urandom_range(3, 0) : mode),
                            i == n - 1);
        end
    endtask

    initial
    begin
        logic [LEN_W-1:0] lens [8];
        rst_n = 1'b0;
        in_valid = 1'b0;
        sample = '0;
        last_sample = 1'b0;
        cfg_valid = 1'b0;
        window_length = '0;
        out_stall = 1'b0;
        hold_off = 1'b0;
        cycle_cnt = 0;
        err_cnt = 0;
        result_cnt = 0;
        record_cnt = 0;
        seen_cnt = 0;
        best_q = '0;
        len_reg = 1;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: window of 1 after reset gives zero spread
        rows.push_back('{32'h0, 1'b1, 0});
        rows.push_back('{32'hFFFF_FFFF, 1'b0, -1});
        rows.push_back('{32'h0, 1'b1, 0});
        foreach (rows[i])
        begin
            send_sample(rows[i].smp, rows[i].lst);
            if (rows[i].want >= 0 && rows[i].lst && spread_q.size() != 0 &&
                spread_q[$] !== rows[i].want[DATA_W-1:0])
            begin
                err_cnt++;
                $display("directed row %0d: table %h predictor %h",
                         i, rows[i].want, spread_q[$]);
            end
        end
        wait_drained();
        rows.delete();
        // window 2: extremes give full range; too short a record gives zero
        write_length(2);
        rows.push_back('{32'h0, 1'b0, -1});
        rows.push_back('{32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF});
        rows.push_back('{32'h1234_5678, 1'b1, 0});
        rows.push_back('{32'h5, 1'b0, -1});
        rows.push_back('{32'h9, 1'b0, -1});
        rows.push_back('{32'h7, 1'b1, 4});
        foreach (rows[i])
        begin
            send_sample(rows[i].smp, rows[i].lst);
            if (rows[i].want >= 0 && rows[i].lst &&
                spread_q[$] !== rows[i].want[DATA_W-1:0])
            begin
                err_cnt++;
                $display("directed row %0d: table %h predictor %h",
                         i, rows[i].want, spread_q[$]);
            end
        end
        wait_drained();
        // zero length acts as one, over-range saturates, change inside a record
        write_length(0);
        send_sample(32'hAAAA_AAAA, 1'b0);
        send_sample(32'h5555_5555, 1'b1);
        wait_drained();
        write_length(11'h7FF);
        random_record(20);
        wait_drained();
        write_length(3);
        send_sample(32'h10, 1'b0);
        send_sample(32'h1, 1'b0);
        send_sample(32'h20, 1'b0);
        wait_drained();
        write_length(2);
        send_sample(32'h3, 1'b1);
        wait_drained();

        // random phases with differing idle patterns and lengths
        lens = '{1, 2, 3, 5, 8, 16, 1024, 1};
        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 12 : ((ph == 1) ? 73 : 0);
            recv_idle_pct = (ph == 0) ? 73 : ((ph == 1) ? 12 : 0);
            for (int r = 0; r < 6; r++)
            begin
                write_length((r == 5) ? lens[$urandom_range(7, 0)]
                                      : LEN_W'($urandom_range(12, 1)));
                if (len_reg == 1024)
                    random_record($urandom_range(40, 1));
                else
                    for (int q = 0; q < 3; q++)
                        random_record($urandom_range(2 * len_reg + 4, 1));
                // receiver holds off while the sender keeps offering records
                if (r == 2)
                    fork
                        long_hold(300);
                        begin
                            random_record(15);
                            random_record(15);
                        end
                    join
                wait_drained();
            end
        end

        wait_drained();
        $display("ran %0d records, %0d spreads checked, window lengths 0..2047 incl. extremes",
                 record_cnt, result_cnt);
        if (err_cnt == 0)
            $display("testbench: done, clean");
        else
            $display("testbench: done, errors");
        $finish;
    end
endmodule
